[src/command_packet_parser_core_defines.svh]
`ifndef COMMAND_PACKET_PARSER_CORE_DEFINES_SVH
`define COMMAND_PACKET_PARSER_CORE_DEFINES_SVH

// Assertion checked only while out of reset.
`define CPP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion checked at every edge, reset included.
`define CPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/cpp_pkg.sv]
package cpp_pkg;

  localparam int unsigned LayerBits = 10;
  localparam logic [3:0] LAYER_NONE = 4'd10;
  localparam logic [2:0] COUNT_MAX = 3'd7;
  localparam logic [2:0] SLOT_FIRST = 3'd0;
  localparam logic [2:0] SLOT_SECOND = 3'd1;
  localparam logic [2:0] SLOT_COMMAND = 3'd2;
  localparam logic [2:0] SLOT_ADDRESS = 3'd3;
  localparam logic [2:0] SLOT_PAYLOAD_HI = 3'd4;
  localparam logic [2:0] SLOT_PAYLOAD_LO = 3'd5;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_LEN   = 2'd1,
    STATUS_LAYER_SET = 2'd2,
    STATUS_NO_LAYER  = 2'd3
  } cpp_status_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } cpp_in_t;

  typedef struct packed {
    cpp_status_e status;
    logic        has_data;
    logic [4:0]  destination;
    logic [3:0]  tracker_layer;
    logic [7:0]  command_code;
    logic [7:0]  target_address;
    logic [15:0] payload;
  } cpp_out_t;

  // Index of the single set bit, or LAYER_NONE.
  function automatic logic [3:0] decode_layer(logic [LayerBits-1:0] flags);
    logic [3:0] idx;
    idx = LAYER_NONE;
    for (int i = 0; i < LayerBits; i++) begin
      if (flags == (LayerBits'(1) << i)) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

endpackage

[src/command_packet_parser_core.sv]
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | cpp_in_t: byte_value, last_byte
// out     | output    | out_valid_o / out_stall_i  | cpp_out_t: status .. payload
// cfg     | input     | cfg_valid_i / cfg_ready_o  | tracker_dest_code, 5 bits
//
// One byte per cycle, unless a stalled result holds a last byte. A byte waits in
// the input register; as it leaves, the packet state updates and a last byte's
// result is loaded into the output register, where it is shown as valid.
// Reset clears the packet state and the tracker code; no clearing pass.
// A stalled result holds back only a last byte behind it; other bytes still flow.
`include "command_packet_parser_core_defines.svh"

module command_packet_parser_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cpp_pkg::cpp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cpp_pkg::cpp_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [4:0]        cfg_data_i
);
  import cpp_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  cpp_in_t    s1_q;
  logic       out_valid_q, out_valid_d;
  cpp_out_t   out_q, res_d;
  logic [4:0] tracker_q;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] first_q, first_d, second_q, second_d;
  logic [7:0] cmd_q, cmd_d, addr_q, addr_d, phi_q, phi_d;
  logic       in_accept, out_free, s1_go;
  logic [7:0] b, lo;
  logic       len_ok, dest_match;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_go       = s1_valid_q && (!s1_q.last_byte || out_free);
  assign in_stall_o  = s1_valid_q && !s1_go;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign b = s1_q.byte_value;

  // Store the byte in its slot, then decode using the updated stores.
  always_comb begin
    first_d  = (cnt_q == SLOT_FIRST)      ? b : first_q;
    second_d = (cnt_q == SLOT_SECOND)     ? b : second_q;
    cmd_d    = (cnt_q == SLOT_COMMAND)    ? b : cmd_q;
    addr_d   = (cnt_q == SLOT_ADDRESS)    ? b : addr_q;
    phi_d    = (cnt_q == SLOT_PAYLOAD_HI) ? b : phi_q;
    lo       = (cnt_q == SLOT_PAYLOAD_LO) ? b : 8'h00;

    res_d.has_data       = first_d[7];
    res_d.destination    = first_d[6:2];
    res_d.tracker_layer  = decode_layer({first_d[1:0], second_d});
    res_d.command_code   = cmd_d;
    res_d.target_address = addr_d;

    len_ok     = res_d.has_data ? (cnt_q == SLOT_PAYLOAD_LO) : (cnt_q == SLOT_ADDRESS);
    dest_match = (res_d.destination == tracker_q);

    if (!len_ok) begin
      res_d.status = STATUS_BAD_LEN;
    end else if (!dest_match && res_d.tracker_layer != LAYER_NONE) begin
      res_d.status = STATUS_LAYER_SET;
    end else if (dest_match && res_d.tracker_layer == LAYER_NONE) begin
      res_d.status = STATUS_NO_LAYER;
    end else begin
      res_d.status = STATUS_OK;
    end

    res_d.payload = (res_d.has_data && cnt_q == SLOT_PAYLOAD_LO) ? {phi_d, lo} : 16'h0000;

    cnt_d = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 3'd1;
    if (s1_q.last_byte) begin
      cnt_d    = 3'd0;
      first_d  = 8'h00;
      second_d = 8'h00;
      cmd_d    = 8'h00;
      addr_d   = 8'h00;
      phi_d    = 8'h00;
    end

    s1_valid_d = in_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);

    if (s1_go && s1_q.last_byte) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tracker_q   <= 5'd0;
      cnt_q       <= 3'd0;
      first_q     <= 8'h00;
      second_q    <= 8'h00;
      cmd_q       <= 8'h00;
      addr_q      <= 8'h00;
      phi_q       <= 8'h00;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tracker_q <= cfg_data_i;
      end
      if (s1_go) begin
        cnt_q    <= cnt_d;
        first_q  <= first_d;
        second_q <= second_d;
        cmd_q    <= cmd_d;
        addr_q   <= addr_d;
        phi_q    <= phi_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_data_i;
    end
    if (s1_go && s1_q.last_byte) begin
      out_q <= res_d;
    end
  end

  `CPP_ASSERT(a_last_gives_result, clk_i, rst_ni,
    s1_go && s1_q.last_byte |=> out_valid_q, "last byte produced no result")
  `CPP_ASSERT(a_last_clears_count, clk_i, rst_ni,
    s1_go && s1_q.last_byte |=> cnt_q == 3'd0, "byte count not cleared after last byte")
  `CPP_ASSERT(a_count_steps, clk_i, rst_ni,
    s1_go && !s1_q.last_byte && cnt_q != COUNT_MAX |=> cnt_q == $past(cnt_q) + 3'd1,
    "byte count did not advance")
  `CPP_ASSERT(a_payload_needs_data, clk_i, rst_ni,
    out_valid_q |-> out_q.has_data || out_q.payload == 16'h0000,
    "payload set without data flag")
  `CPP_ASSERT_ALWAYS(a_no_stall_when_empty, clk_i,
    !s1_valid_q |-> !in_stall_o, "input stalled with empty input register")

endmodule
